/* rtl/core/rcr_pkg.sv */
// Shared types and constants for the range capacity reservation core.
// No dependencies; imported by rcr_taken_store and the top level.
package rcr_pkg;

	localparam int SLOT_W = 11;
	localparam int AMT_W  = 32;
	localparam int CAP_W  = 48;
	localparam int NUM_W  = 32;

	// configuration register indexes
	localparam logic CFG_SLOT_COUNT = 1'b0;
	localparam logic CFG_CAPACITY   = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_COUNT_RST = 11'd1024;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_SCN_RD = 7'b0000100,
		ST_SCN_AC = 7'b0001000,
		ST_DECIDE = 7'b0010000,
		ST_UPD_RD = 7'b0100000,
		ST_UPD_WR = 7'b1000000
	} state_t;

	typedef struct packed {
		logic we;     // write the addressed entry
		logic clear;  // write zero instead of entry + amount
	} store_ctrl_t;

endpackage

/* rtl/core/rcr_taken_store.sv */
// Per-slot taken-amount memory with a registered read port and an add-on-write path.
// Depends on rcr_pkg.
module rcr_taken_store #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                          clk,
	input  rcr_pkg::store_ctrl_t          ctrl,
	input  logic [$clog2(MAX_SLOTS)-1:0]  addr,
	input  logic [rcr_pkg::AMT_W-1:0]     amount,
	output logic [rcr_pkg::CAP_W-1:0]     rdata
);
	import rcr_pkg::*;

	logic [CAP_W-1:0] mem [MAX_SLOTS];
	logic [CAP_W-1:0] rdata_q;
	logic [CAP_W-1:0] wdata;

	// read-modify-write: rdata_q holds the entry read the cycle before
	assign wdata = ctrl.clear ? '0 : rdata_q + {{(CAP_W-AMT_W){1'b0}}, amount};

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/range_capacity_reservation_core.sv */
// Range capacity reservation core: admission control over a row of slots.
// Depends on rcr_pkg and rcr_taken_store.
//
// Each request word names an inclusive slot range and an amount; the core scans
// the per-slot taken amounts over the range, one slot at a time through a
// single-port memory (a read state, then an accumulate state), and grants the
// request if capacity minus the largest taken amount covers the amount; a granted
// request with a nonzero amount then walks the range again adding the amount (a
// read state, then a write state, per slot). Empty or out-of-range requests are
// answered without a scan. After reset a clearing pass writes zero to every slot
// before the first request word is taken. Configuration writes are always taken.
module range_capacity_reservation_core #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [rcr_pkg::SLOT_W-1:0]    first_slot,
	input  logic [rcr_pkg::SLOT_W-1:0]    last_slot,
	input  logic [rcr_pkg::AMT_W-1:0]     amount,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          accepted,
	output logic [rcr_pkg::NUM_W-1:0]     request_number,
	output logic [rcr_pkg::CAP_W-1:0]     min_remaining,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [rcr_pkg::CAP_W-1:0]     cfg_data
);
	import rcr_pkg::*;

	localparam int AW = $clog2(MAX_SLOTS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

	state_t            state_q;
	logic [AW-1:0]     addr_q, end_q, start_q;
	logic [CAP_W-1:0]  max_q, rem_q, cap_q;
	logic [SLOT_W-1:0] slot_cnt_q;
	logic [AMT_W-1:0]  amt_q;
	logic              acc_q, out_q;
	logic [NUM_W-1:0]  cnt_q;
	logic [CAP_W-1:0]  rdata, remaining;
	logic [31:0]       first_m1, last_m1;
	logic              req_acc, out_of_range;
	store_ctrl_t       sctrl;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE) || out_q;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = out_q;
	assign accepted       = acc_q;
	assign request_number = cnt_q;
	assign min_remaining  = rem_q;

	assign first_m1 = {21'b0, first_slot} - 32'd1;
	assign last_m1  = {21'b0, last_slot} - 32'd1;
	assign out_of_range = (first_slot == '0) || (last_slot > slot_cnt_q)
		|| ({21'b0, last_slot} > 32'(MAX_SLOTS));
	assign remaining = (max_q >= cap_q) ? '0 : cap_q - max_q;

	assign sctrl.we    = (state_q == ST_CLEAR) || (state_q == ST_UPD_WR);
	assign sctrl.clear = (state_q == ST_CLEAR);

	rcr_taken_store #(.MAX_SLOTS(MAX_SLOTS)) u_store (
		.clk    (clk),
		.ctrl   (sctrl),
		.addr   (addr_q),
		.amount (amt_q),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q <= SLOT_COUNT_RST;
			cap_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SLOT_COUNT: slot_cnt_q <= cfg_data[SLOT_W-1:0];
				CFG_CAPACITY:   cap_q      <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			amt_q <= amount;
			end_q <= last_m1[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			out_q   <= 1'b0;
			cnt_q   <= '0;
			acc_q   <= 1'b0;
			rem_q   <= '0;
			max_q   <= '0;
		end else begin
			if (out_q && !rsp_stall) begin
				out_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						cnt_q <= cnt_q + 1'b1;
						if (first_slot > last_slot) begin
							acc_q <= 1'b1;
							rem_q <= cap_q;
							out_q <= 1'b1;
						end else if (out_of_range) begin
							acc_q <= 1'b0;
							rem_q <= '0;
							out_q <= 1'b1;
						end else begin
							addr_q  <= first_m1[AW-1:0];
							max_q   <= '0;
							state_q <= ST_SCN_RD;
						end
					end
				end
				ST_SCN_RD: state_q <= ST_SCN_AC;
				ST_SCN_AC: begin
					if (rdata > max_q) begin
						max_q <= rdata;
					end
					if (addr_q == end_q) begin
						state_q <= ST_DECIDE;
					end else begin
						addr_q  <= addr_q + 1'b1;
						state_q <= ST_SCN_RD;
					end
				end
				ST_DECIDE: begin
					rem_q <= remaining;
					acc_q <= remaining >= {{(CAP_W-AMT_W){1'b0}}, amt_q};
					if (remaining >= {{(CAP_W-AMT_W){1'b0}}, amt_q} && amt_q != '0) begin
						addr_q  <= start_q;
						state_q <= ST_UPD_RD;
					end else begin
						out_q   <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_UPD_RD: state_q <= ST_UPD_WR;
				ST_UPD_WR: begin
					if (addr_q == end_q) begin
						out_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						addr_q  <= addr_q + 1'b1;
						state_q <= ST_UPD_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// first_slot is held stable on the request side only until accept, so the
	// update walk restarts from the saved start address
	always_ff @(posedge clk) begin
		if (req_acc) begin
			start_q <= first_m1[AW-1:0];
		end
	end

	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall) else $error("request taken while a result is pending");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("request number did not advance");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_WR) |-> (addr_q <= end_q))
		else $error("update walk past end of range");

endmodule

/* tb/range_capacity_reservation_core_test.sv */
// Testbench for range_capacity_reservation_core: directed and random reservation requests,
// checked against a per-slot model of taken amounts kept in the bench.
// Depends on rcr_pkg and the core RTL.
`timescale 1ns / 1ps
module range_capacity_reservation_core_test;
	import rcr_pkg::*;

	localparam int NSLOT = 1024;

	typedef struct packed {
		logic             acc;
		logic [NUM_W-1:0] num;
		logic [CAP_W-1:0] rem;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [SLOT_W-1:0] first_slot = '0;
	logic [SLOT_W-1:0] last_slot = '0;
	logic [AMT_W-1:0] amount = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic accepted;
	logic [NUM_W-1:0] request_number;
	logic [CAP_W-1:0] min_remaining;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [CAP_W-1:0] cfg_data = '0;

	// bench copy of block state
	logic [CAP_W-1:0] taken [1:NSLOT];
	logic [SLOT_W-1:0] m_slot_count;
	logic [CAP_W-1:0] m_capacity;
	logic [NUM_W-1:0] m_counter;
	grant_t pending_grants[$];
	int errors = 0;
	bit idle_on = 1'b1;
	int hold_cycles = 0;

	range_capacity_reservation_core #(.MAX_SLOTS(NSLOT)) DUT (.*);

	always #5 clk = ~clk;

	function automatic grant_t predict_grant(logic [SLOT_W-1:0] f, logic [SLOT_W-1:0] l,
			logic [AMT_W-1:0] a);
		grant_t g;
		logic [CAP_W-1:0] mx;
		int lim;
		mx = '0;
		lim = (m_slot_count < NSLOT) ? m_slot_count : NSLOT;
		m_counter = m_counter + 1'b1;
		g.num = m_counter;
		if (f > l) begin
			g.acc = 1'b1;
			g.rem = m_capacity;
		end else if (f == 0 || l > lim) begin
			g.acc = 1'b0;
			g.rem = '0;
		end else begin
			for (int i = f; i <= l; i++)
				if (taken[i] > mx) mx = taken[i];
			g.rem = (mx >= m_capacity) ? '0 : m_capacity - mx;
			g.acc = (g.rem >= a);
			if (g.acc)
				for (int i = f; i <= l; i++) taken[i] = taken[i] + a;
		end
		return g;
	endfunction

	// valid stays up after accept until the next word replaces it or an idle
	// stretch, drain or register write drops it
	task automatic send_request(logic [SLOT_W-1:0] f, logic [SLOT_W-1:0] l, logic [AMT_W-1:0] a);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_valid <= 1'b1;
		first_slot <= f;
		last_slot <= l;
		amount <= a;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_grants = {pending_grants, predict_grant(f, l, a)};
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		req_valid <= 1'b0;
		while (pending_grants.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CAP_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SLOT_COUNT) m_slot_count = val[SLOT_W-1:0];
		else m_capacity = val;
	endtask

	// response checker and receiver stall
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result num=%0d", $time, request_number);
				errors++;
			end else begin
				grant_t e;
				e = pending_grants.pop_front();
				if (e.acc !== accepted || e.num !== request_number || e.rem !== min_remaining) begin
					$display("%0t: mismatch expected acc=%0d num=%0d rem=%0d got acc=%0d num=%0d rem=%0d",
						$time, e.acc, e.num, e.rem, accepted, request_number, min_remaining);
					errors++;
				end
			end
		end
	end

	initial begin
		int burst;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else if (idle_on && burst == 0 && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 15);
				rsp_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				rsp_stall <= (burst != 0);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic test_directed;
		write_reg(CFG_CAPACITY, 48'd100);
		send_request(11'd1, 11'd1024, 32'd0);
		send_request(11'd1, 11'd1024, 32'd40);
		send_request(11'd5, 11'd5, 32'd60);
		send_request(11'd5, 11'd5, 32'd1);
		send_request(11'd10, 11'd3, 32'hFFFF_FFFF);
		send_request(11'd0, 11'd4, 32'd1);
		send_request(11'd1, 11'd1025, 32'd1);
		send_request(11'd2047, 11'd2047, 32'd1);
		send_request(11'd1024, 11'd1024, 32'd60);
		send_request(11'd1, 11'd2, 32'hFFFF_FFFF);
		write_reg(CFG_CAPACITY, 48'd20);   // lowered below taken
		send_request(11'd5, 11'd5, 32'd1);
		send_request(11'd5, 11'd5, 32'd0);
		write_reg(CFG_SLOT_COUNT, 48'd0);
		send_request(11'd1, 11'd1, 32'd0);
		send_request(11'd3, 11'd1, 32'd0);
		write_reg(CFG_SLOT_COUNT, 48'd2047);
		send_request(11'd1000, 11'd1024, 32'd0);
		write_reg(CFG_CAPACITY, 48'hFFFF_FFFF_FFFF);
		send_request(11'd1, 11'd1024, 32'hFFFF_FFFF);
		send_request(11'd512, 11'd513, 32'h8000_0000);
	endtask

	task automatic random_phase(int n, int maxspan);
		logic [SLOT_W-1:0] f, l;
		logic [AMT_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					f = SLOT_W'($urandom);
					l = SLOT_W'($urandom);
				end
				1: begin
					f = SLOT_W'($urandom_range(2, 1024));
					l = SLOT_W'(f - $urandom_range(1, f - 1));
				end
				default: begin
					f = SLOT_W'($urandom_range(1, 1024));
					l = SLOT_W'(f + $urandom_range(0, maxspan));
					if (l > 1024 && $urandom_range(0, 3) != 0) l = 11'd1024;
				end
			endcase
			case ($urandom_range(0, 4))
				0: a = $urandom;
				1: a = '0;
				default: a = AMT_W'($urandom_range(0, 5000));
			endcase
			send_request(f, l, a);
		end
	endtask

	task automatic test_random;
		write_reg(CFG_SLOT_COUNT, 48'd1024);
		write_reg(CFG_CAPACITY, 48'd200000);
		random_phase(250, 16);
		write_reg(CFG_SLOT_COUNT, 48'd1);
		random_phase(50, 3);
		write_reg(CFG_SLOT_COUNT, 48'd700);
		write_reg(CFG_CAPACITY, CAP_W'({$urandom, $urandom}));
		random_phase(250, 40);
	endtask

	task automatic test_backpressure;
		hold_cycles = 400;
		random_phase(30, 4);
		drain();           // sender waits for every result
		random_phase(20, 4);
	endtask

	task automatic test_no_idle;
		idle_on = 1'b0;
		write_reg(CFG_SLOT_COUNT, 48'd1024);
		write_reg(CFG_CAPACITY, 48'd300000);
		random_phase(220, 8);
	endtask

	initial begin
		for (int i = 1; i <= NSLOT; i++) taken[i] = '0;
		m_slot_count = SLOT_COUNT_RST;
		m_capacity = '0;
		m_counter = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_backpressure();
		test_no_idle();
		drain();
		if (errors == 0 && pending_grants.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#30ms;
		$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/rcr_pkg.sv
rtl/core/rcr_taken_store.sv
rtl/core/range_capacity_reservation_core.sv
tb/range_capacity_reservation_core_test.sv
